[hdl/sac_pkg.sv]
package sac_pkg;

  localparam int LINE_NUM_W = 59;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_WB    = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
    logic [31:0] write_data;
    logic [31:0] mem_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] out_address;
    logic [31:0] out_data;
    logic        last;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_MISS,
    ST_WB_RD,
    ST_WB_OUT,
    ST_INVAL,
    ST_FETCH,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_DATA_RD,
    ST_DATA_RD2,
    ST_MERGE,
    ST_WR1,
    ST_META_A,
    ST_META_B,
    ST_RESP
  } state_t;

endpackage

[hdl/sac_stream_if.sv]
interface sac_stream_if #(parameter type item_t = sac_pkg::req_t);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/sac_way_sel.sv]
module sac_way_sel #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 51,
  parameter int WAY_W = 3
) (
  input  logic [WAYS-1:0][TAG_W+33:0] row,
  input  logic [TAG_W-1:0]            tag,
  output logic                        hit,
  output logic [WAY_W-1:0]            hit_way,
  output logic [WAY_W-1:0]            victim
);

  // row entry: {valid, dirty, age[31:0], tag}
  logic [31:0] best_age;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    victim   = '0;
    best_age = row[0][TAG_W+31:TAG_W];
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w][TAG_W+33] && row[w][TAG_W-1:0] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // strict compare keeps the lowest way on ties
    for (int w = 1; w < WAYS; w++) begin
      if (row[w][TAG_W+31:TAG_W] < best_age) begin
        best_age = row[w][TAG_W+31:TAG_W];
        victim   = WAY_W'(w);
      end
    end
  end

endmodule

[hdl/set_assoc_writeback_lru_cache_core.sv]
// Write-back, write-allocate data cache, SETS sets of WAYS ways, 32-byte lines, LRU
// replacement by access age. After reset a clearing pass over all SETS sets runs before
// the first beat is taken. One request beat is taken at a time; a hit runs through a
// meta read, one or two tag checks, two data reads, up to two data writes, meta
// write-back and the response beat. A miss adds a writeback of 8 words for a dirty
// victim, each word read and then sent as a beat, and ends with a fetch beat; 8 fill
// beats then complete the line and the access retries. Reads or writes that arrive while
// a fetch is outstanding, fills with nothing outstanding and op 3 are dropped. SETS must
// be a power of two.
module set_assoc_writeback_lru_cache_core #(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input logic clk,
  input logic rst,
  sac_stream_if.sink   req,
  sac_stream_if.source rsp
);

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W = sac_pkg::LINE_NUM_W - SET_W;
  localparam int MW    = TAG_W + 34;
  localparam int DA_W  = SET_W + WAY_W + 3;

  typedef logic [WAYS-1:0][MW-1:0] row_t;

  sac_pkg::state_t state, state_next;

  logic [SET_W-1:0]                clr_idx;
  logic [31:0]                     count;
  logic                            p_wr;
  logic [63:0]                     p_addr;
  logic [31:0]                     p_data;
  logic                            miss_pend;
  logic [sac_pkg::LINE_NUM_W-1:0]  miss_line;
  logic [WAY_W-1:0]                miss_way;
  logic [2:0]                      fill_idx;
  logic [2:0]                      wb_idx;
  row_t                            row_a, row_b, row_v;
  logic [WAY_W-1:0]                way_a, way_b;
  logic [31:0]                     word0;
  logic [63:0]                     merged;
  logic [31:0]                     result;
  logic                            out_valid;
  sac_pkg::rsp_t                   out_item, out_next;
  logic                            load_out;

  row_t             meta_mem [SETS];
  row_t             meta_rd, meta_wdata;
  logic             meta_re, meta_we;
  logic [SET_W-1:0] meta_raddr, meta_waddr;

  logic [31:0]      data_mem [1 << DA_W];
  logic [31:0]      data_rd, data_wdata;
  logic             data_re, data_we;
  logic [DA_W-1:0]  data_raddr, data_waddr;

  logic [sac_pkg::LINE_NUM_W-1:0] la, lb;
  logic [4:0]       off;
  logic             straddle, two_words, in_acc, slot_free;
  logic [SET_W-1:0] set_a, set_b, set_m;
  logic [TAG_W-1:0] sel_tag;
  logic             hit;
  logic [WAY_W-1:0] hit_way, victim;
  logic [63:0]      dbl, merged_c, wmask;
  logic [5:0]       sh;
  logic [31:0]      rd_c;

  assign la        = p_addr[63:5];
  assign lb        = la + sac_pkg::LINE_NUM_W'(1);
  assign off       = p_addr[4:0];
  assign two_words = off[1:0] != 2'd0;
  assign straddle  = off[4:2] == 3'd7 && two_words;
  assign set_a     = la[SET_W-1:0];
  assign set_b     = lb[SET_W-1:0];
  assign set_m     = miss_line[SET_W-1:0];
  assign sel_tag   = (state == sac_pkg::ST_LOOK_B) ? lb[sac_pkg::LINE_NUM_W-1:SET_W]
                                                   : la[sac_pkg::LINE_NUM_W-1:SET_W];
  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = state == sac_pkg::ST_IDLE;
  assign in_acc    = req.valid && req.ready;

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  // little-endian byte window over the two touched words
  assign dbl      = {data_rd, word0};
  assign sh       = {off[1:0], 3'b000};
  assign rd_c     = 32'(dbl >> sh);
  assign wmask    = 64'h0000_0000_FFFF_FFFF << sh;
  assign merged_c = (dbl & ~wmask) | (64'(p_data) << sh);

  sac_way_sel #(.WAYS(WAYS), .TAG_W(TAG_W), .WAY_W(WAY_W)) u_way_sel (
    .row     (meta_rd),
    .tag     (sel_tag),
    .hit     (hit),
    .hit_way (hit_way),
    .victim  (victim)
  );

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rd <= data_mem[data_raddr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sac_pkg::ST_CLEAR: begin
        if (clr_idx == SET_W'(SETS - 1)) state_next = sac_pkg::ST_IDLE;
      end
      sac_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((req.payload.op == sac_pkg::OP_READ || req.payload.op == sac_pkg::OP_WRITE)
              && !miss_pend) begin
            state_next = sac_pkg::ST_START;
          end else if (req.payload.op == sac_pkg::OP_FILL && miss_pend && fill_idx == 3'd7) begin
            state_next = sac_pkg::ST_FILL_RD;
          end
        end
      end
      sac_pkg::ST_START:    state_next = sac_pkg::ST_LOOK_A;
      sac_pkg::ST_LOOK_A: begin
        if (!hit) state_next = sac_pkg::ST_MISS;
        else if (straddle) state_next = sac_pkg::ST_LOOK_B;
        else state_next = sac_pkg::ST_DATA_RD;
      end
      sac_pkg::ST_LOOK_B:   state_next = hit ? sac_pkg::ST_DATA_RD : sac_pkg::ST_MISS;
      sac_pkg::ST_MISS: begin
        state_next = (row_v[miss_way][MW-1] && row_v[miss_way][MW-2]) ? sac_pkg::ST_WB_RD
                                                                      : sac_pkg::ST_INVAL;
      end
      sac_pkg::ST_WB_RD:    state_next = sac_pkg::ST_WB_OUT;
      sac_pkg::ST_WB_OUT: begin
        if (slot_free) state_next = (wb_idx == 3'd7) ? sac_pkg::ST_INVAL : sac_pkg::ST_WB_RD;
      end
      sac_pkg::ST_INVAL:    state_next = sac_pkg::ST_FETCH;
      sac_pkg::ST_FETCH: begin
        if (slot_free) state_next = sac_pkg::ST_IDLE;
      end
      sac_pkg::ST_FILL_RD:  state_next = sac_pkg::ST_FILL_WR;
      sac_pkg::ST_FILL_WR:  state_next = sac_pkg::ST_START;
      sac_pkg::ST_DATA_RD:  state_next = sac_pkg::ST_DATA_RD2;
      sac_pkg::ST_DATA_RD2: state_next = sac_pkg::ST_MERGE;
      sac_pkg::ST_MERGE:    state_next = (p_wr && two_words) ? sac_pkg::ST_WR1
                                                             : sac_pkg::ST_META_A;
      sac_pkg::ST_WR1:      state_next = sac_pkg::ST_META_A;
      sac_pkg::ST_META_A:   state_next = straddle ? sac_pkg::ST_META_B : sac_pkg::ST_RESP;
      sac_pkg::ST_META_B:   state_next = sac_pkg::ST_RESP;
      sac_pkg::ST_RESP: begin
        if (slot_free) state_next = sac_pkg::ST_IDLE;
      end
      default:              state_next = sac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    meta_re    = 1'b0;
    meta_raddr = set_a;
    meta_we    = 1'b0;
    meta_waddr = set_a;
    meta_wdata = row_a;
    data_re    = 1'b0;
    data_raddr = {set_a, way_a, off[4:2]};
    data_we    = 1'b0;
    data_waddr = {set_a, way_a, off[4:2]};
    data_wdata = merged_c[31:0];
    load_out   = 1'b0;
    out_next   = '0;
    unique case (state)
      sac_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
      end
      sac_pkg::ST_IDLE: begin
        if (in_acc && req.payload.op == sac_pkg::OP_FILL && miss_pend) begin
          data_we    = 1'b1;
          data_waddr = {set_m, miss_way, fill_idx};
          data_wdata = req.payload.mem_word;
        end
      end
      sac_pkg::ST_START: begin
        meta_re = 1'b1;
      end
      sac_pkg::ST_LOOK_A: begin
        if (hit && straddle) begin
          meta_re    = 1'b1;
          meta_raddr = set_b;
        end
      end
      sac_pkg::ST_FILL_RD: begin
        meta_re    = 1'b1;
        meta_raddr = set_m;
      end
      sac_pkg::ST_FILL_WR: begin
        meta_we    = 1'b1;
        meta_waddr = set_m;
        meta_wdata = meta_rd;
        meta_wdata[miss_way] = {1'b1, 1'b0, count, miss_line[sac_pkg::LINE_NUM_W-1:SET_W]};
      end
      sac_pkg::ST_WB_RD: begin
        data_re    = 1'b1;
        data_raddr = {set_m, miss_way, wb_idx};
      end
      sac_pkg::ST_WB_OUT: begin
        load_out             = slot_free;
        out_next.kind        = sac_pkg::KIND_WB;
        out_next.out_address = {row_v[miss_way][TAG_W-1:0], set_m, wb_idx, 2'b00};
        out_next.out_data    = data_rd;
      end
      sac_pkg::ST_INVAL: begin
        meta_we    = 1'b1;
        meta_waddr = set_m;
        meta_wdata = row_v;
        meta_wdata[miss_way][MW-1:MW-2] = 2'b00;
      end
      sac_pkg::ST_FETCH: begin
        load_out             = slot_free;
        out_next.kind        = sac_pkg::KIND_FETCH;
        out_next.out_address = {miss_line, 5'b00000};
        out_next.last        = 1'b1;
      end
      sac_pkg::ST_DATA_RD: begin
        data_re = 1'b1;
      end
      sac_pkg::ST_DATA_RD2: begin
        data_re    = 1'b1;
        data_raddr = straddle ? {set_b, way_b, 3'd0} : {set_a, way_a, off[4:2] + 3'd1};
      end
      sac_pkg::ST_MERGE: begin
        data_we = p_wr;
      end
      sac_pkg::ST_WR1: begin
        data_we    = 1'b1;
        data_waddr = straddle ? {set_b, way_b, 3'd0} : {set_a, way_a, off[4:2] + 3'd1};
        data_wdata = merged[63:32];
      end
      sac_pkg::ST_META_A: begin
        meta_we = 1'b1;
        meta_wdata[way_a][TAG_W+31:TAG_W] = count;
        meta_wdata[way_a][MW-2] = row_a[way_a][MW-2] | p_wr;
      end
      sac_pkg::ST_META_B: begin
        meta_we    = 1'b1;
        meta_waddr = set_b;
        meta_wdata = row_b;
        meta_wdata[way_b][TAG_W+31:TAG_W] = count;
        meta_wdata[way_b][MW-2] = row_b[way_b][MW-2] | p_wr;
      end
      sac_pkg::ST_RESP: begin
        load_out          = slot_free;
        out_next.kind     = p_wr ? sac_pkg::KIND_WRITE : sac_pkg::KIND_READ;
        out_next.out_data = p_wr ? 32'd0 : result;
        out_next.last     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sac_pkg::ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      miss_pend <= 1'b0;
      fill_idx  <= '0;
      wb_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sac_pkg::ST_CLEAR) clr_idx <= clr_idx + SET_W'(1);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        sac_pkg::ST_IDLE: begin
          if (in_acc && !miss_pend &&
              (req.payload.op == sac_pkg::OP_READ || req.payload.op == sac_pkg::OP_WRITE)) begin
            count <= count + 32'd1;
          end
          if (in_acc && miss_pend && req.payload.op == sac_pkg::OP_FILL) begin
            fill_idx <= fill_idx + 3'd1;
          end
        end
        sac_pkg::ST_MISS:    wb_idx <= '0;
        sac_pkg::ST_WB_OUT: begin
          if (slot_free) wb_idx <= wb_idx + 3'd1;
        end
        sac_pkg::ST_FETCH: begin
          if (slot_free) begin
            miss_pend <= 1'b1;
            fill_idx  <= '0;
          end
        end
        sac_pkg::ST_FILL_WR: miss_pend <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_out) out_item <= out_next;
    unique case (state)
      sac_pkg::ST_IDLE: begin
        if (in_acc && !miss_pend &&
            (req.payload.op == sac_pkg::OP_READ || req.payload.op == sac_pkg::OP_WRITE)) begin
          p_wr   <= req.payload.op == sac_pkg::OP_WRITE;
          p_addr <= req.payload.address;
          p_data <= req.payload.write_data;
        end
      end
      sac_pkg::ST_LOOK_A: begin
        row_a <= meta_rd;
        way_a <= hit_way;
        if (!hit) begin
          miss_line <= la;
          miss_way  <= victim;
          row_v     <= meta_rd;
        end
      end
      sac_pkg::ST_LOOK_B: begin
        row_b <= meta_rd;
        way_b <= hit_way;
        if (!hit) begin
          miss_line <= lb;
          miss_way  <= victim;
          row_v     <= meta_rd;
        end
      end
      sac_pkg::ST_DATA_RD2: word0 <= data_rd;
      sac_pkg::ST_MERGE: begin
        merged <= merged_c;
        result <= rd_c;
      end
      default: begin
      end
    endcase
  end

endmodule

[test/cache_scoreboard.sv]
`timescale 1ns / 100ps

module cache_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  sac_pkg::req_t req_beat,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  sac_pkg::rsp_t rsp_beat,
  output int            fail_count,
  output int            outstanding,
  output bit            miss_pending
);

  localparam int N_SETS = 256;
  localparam int N_WAYS = 8;
  localparam int N_WORDS = 8;

  logic [50:0] tag_mem [N_SETS*N_WAYS];
  bit          valid_mem [N_SETS*N_WAYS];
  bit          dirty_mem [N_SETS*N_WAYS];
  bit   [31:0] age_mem [N_SETS*N_WAYS];
  bit   [31:0] word_mem [N_SETS*N_WAYS*N_WORDS];
  bit   [31:0] access_cnt;

  // the access waiting for its line
  bit          pend_v;
  logic [1:0]  pend_op;
  logic [63:0] pend_addr;
  logic [31:0] pend_data;
  logic [58:0] pend_line;
  int          pend_way;
  int          fill_idx;

  sac_pkg::rsp_t exp_rsp [$];

  assign outstanding  = exp_rsp.size();
  assign miss_pending = pend_v;

  function automatic void push_rsp(logic [1:0] k, logic [63:0] a, logic [31:0] d, logic l);
    sac_pkg::rsp_t r;
    r.kind = k;
    r.out_address = a;
    r.out_data = d;
    r.last = l;
    exp_rsp.push_back(r);
  endfunction

  function automatic bit find_line(logic [58:0] ln, output int slot);
    int set_i;
    set_i = int'(ln[7:0]);
    slot = 0;
    for (int w = 0; w < N_WAYS; w++) begin
      if (valid_mem[set_i*N_WAYS+w] && tag_mem[set_i*N_WAYS+w] == ln[58:8]) begin
        slot = set_i*N_WAYS + w;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void begin_miss(logic [58:0] ln);
    int set_i;
    int best;
    int s;
    logic [58:0] victim_line;
    set_i = int'(ln[7:0]);
    best = 0;
    for (int w = 1; w < N_WAYS; w++)
      if (age_mem[set_i*N_WAYS+w] < age_mem[set_i*N_WAYS+best]) best = w;
    s = set_i*N_WAYS + best;
    if (valid_mem[s] && dirty_mem[s]) begin
      victim_line = {tag_mem[s], ln[7:0]};
      for (int i = 0; i < N_WORDS; i++)
        push_rsp(sac_pkg::KIND_WB, {victim_line, 5'd0} + 64'(4*i), word_mem[s*N_WORDS+i],
                 1'b0);
    end
    valid_mem[s] = 0;
    dirty_mem[s] = 0;
    push_rsp(sac_pkg::KIND_FETCH, {ln, 5'd0}, 32'd0, 1'b1);
    pend_v = 1;
    pend_line = ln;
    pend_way = best;
    fill_idx = 0;
  endfunction

  function automatic void run_access();
    logic [58:0] la;
    logic [58:0] lb;
    int off;
    int sa;
    int sb;
    int p;
    int s;
    int idx;
    int sh;
    bit straddle;
    bit is_wr;
    logic [31:0] rd;
    la = pend_addr[63:5];
    lb = la + 59'd1;
    off = int'(pend_addr[4:0]);
    straddle = off >= 29;
    is_wr = pend_op == sac_pkg::OP_WRITE;
    rd = '0;
    if (!find_line(la, sa)) begin
      begin_miss(la);
      return;
    end
    if (straddle && !find_line(lb, sb)) begin
      begin_miss(lb);
      return;
    end
    for (int k = 0; k < 4; k++) begin
      p = off + k;
      s = (p < 32) ? sa : sb;
      idx = s*N_WORDS + ((p & 31) >> 2);
      sh = (p & 3) * 8;
      if (is_wr)
        word_mem[idx] = (word_mem[idx] & ~(32'hFF << sh)) | (32'(pend_data[8*k +: 8]) << sh);
      else
        rd[8*k +: 8] = word_mem[idx][sh +: 8];
    end
    age_mem[sa] = access_cnt;
    if (is_wr) dirty_mem[sa] = 1;
    if (straddle) begin
      age_mem[sb] = access_cnt;
      if (is_wr) dirty_mem[sb] = 1;
    end
    pend_v = 0;
    if (is_wr) push_rsp(sac_pkg::KIND_WRITE, '0, '0, 1'b1);
    else push_rsp(sac_pkg::KIND_READ, '0, rd, 1'b1);
  endfunction

  function automatic void take_beat(sac_pkg::req_t b);
    int s;
    if (b.op == sac_pkg::OP_READ || b.op == sac_pkg::OP_WRITE) begin
      if (pend_v) return;
      access_cnt++;
      pend_op = b.op;
      pend_addr = b.address;
      pend_data = b.write_data;
      run_access();
    end else if (b.op == sac_pkg::OP_FILL) begin
      if (!pend_v) return;
      s = int'(pend_line[7:0])*N_WAYS + pend_way;
      word_mem[s*N_WORDS + fill_idx] = b.mem_word;
      fill_idx++;
      if (fill_idx < N_WORDS) return;
      fill_idx = 0;
      tag_mem[s] = pend_line[58:8];
      valid_mem[s] = 1;
      dirty_mem[s] = 0;
      age_mem[s] = access_cnt;
      run_access();
    end
  endfunction

  always @(posedge clk) begin
    sac_pkg::rsp_t e;
    if (rst) begin
      fail_count = 0;
      access_cnt = 0;
      pend_v = 0;
      fill_idx = 0;
      exp_rsp.delete();
      foreach (valid_mem[i]) begin
        valid_mem[i] = 0;
        dirty_mem[i] = 0;
        age_mem[i] = 0;
        tag_mem[i] = '0;
      end
    end else begin
      if (req_valid && req_ready) take_beat(req_beat);
      if (rsp_valid && rsp_ready) begin
        if (exp_rsp.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat kind=%0d addr=%h data=%h last=%0d", $time,
                   rsp_beat.kind, rsp_beat.out_address, rsp_beat.out_data, rsp_beat.last);
        end else begin
          e = exp_rsp.pop_front();
          if (e.kind !== rsp_beat.kind) begin
            fail_count++;
            $display("%0t: kind expected %0d got %0d", $time, e.kind, rsp_beat.kind);
          end
          if (e.out_address !== rsp_beat.out_address) begin
            fail_count++;
            $display("%0t: out_address expected %h got %h", $time, e.out_address,
                     rsp_beat.out_address);
          end
          if (e.out_data !== rsp_beat.out_data) begin
            fail_count++;
            $display("%0t: out_data expected %h got %h", $time, e.out_data, rsp_beat.out_data);
          end
          if (e.last !== rsp_beat.last) begin
            fail_count++;
            $display("%0t: last expected %0d got %0d", $time, e.last, rsp_beat.last);
          end
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  bit   miss_pending;
  int   send_idle_pct;
  int   stall_pct;
  bit   hold_rsp;
  logic [50:0] tag_pool [12];
  logic [7:0]  set_pool [6];

  sac_stream_if #(.item_t(sac_pkg::req_t)) req_ch ();
  sac_stream_if #(.item_t(sac_pkg::rsp_t)) rsp_ch ();

  set_assoc_writeback_lru_cache_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cache_scoreboard scoreboard (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .req_beat     (req_ch.payload),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .rsp_beat     (rsp_ch.payload),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .miss_pending (miss_pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("set_assoc_writeback_lru_cache_core regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 0;
    end else begin
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  // called and returns at a rising edge; leaves valid high on the accepting edge
  task automatic send_beat(logic [1:0] op, logic [63:0] addr, logic [31:0] wd, logic [31:0] mw);
    sac_pkg::req_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    b.op = op;
    b.address = addr;
    b.write_data = wd;
    b.mem_word = mw;
    req_ch.valid <= 1;
    req_ch.payload <= b;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_noise();
    if ($urandom_range(1))
      send_beat(sac_pkg::OP_NOP, {$urandom, $urandom}, $urandom, $urandom);
    else
      send_beat(miss_pending ? 2'($urandom_range(1)) : sac_pkg::OP_FILL, {$urandom, $urandom},
                $urandom, $urandom);
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // serve line fetches until nothing is outstanding
  task automatic settle(bit noisy);
    wait_quiet();
    while (miss_pending) begin
      for (int i = 0; i < 8; i++) begin
        if (noisy && $urandom_range(9) == 0) send_noise();
        send_beat(sac_pkg::OP_FILL, {$urandom, $urandom}, $urandom, $urandom);
      end
      wait_quiet();
    end
  endtask

  task automatic access(logic [1:0] op, logic [63:0] addr, bit noisy);
    send_beat(op, addr, $urandom, $urandom);
    settle(noisy);
  endtask

  function automatic logic [63:0] pick_addr();
    logic [7:0] s;
    s = ($urandom_range(3) == 0) ? 8'($urandom) : set_pool[$urandom_range(5)];
    return {tag_pool[$urandom_range(11)], s, 5'($urandom)};
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_noise();
      access(2'($urandom_range(1)), pick_addr(), 1);
    end
  endtask

  initial begin
    rst = 1;
    hold_rsp = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    req_ch.valid = 0;
    req_ch.payload = '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 12; i++) tag_pool[i] = {19'($urandom), $urandom};
    set_pool = '{8'd0, 8'd1, 8'd3, 8'd254, 8'd255, 8'd128};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: cold misses, byte offsets, straddles, wraps, dirty eviction
    access(sac_pkg::OP_WRITE, 64'h0, 0);
    access(sac_pkg::OP_READ, 64'h0, 0);
    access(sac_pkg::OP_WRITE, 64'h1D, 0);
    access(sac_pkg::OP_READ, 64'h1E, 0);
    access(sac_pkg::OP_WRITE, 64'h1F, 0);
    access(sac_pkg::OP_READ, {tag_pool[1], 8'd255, 5'd31}, 0);
    access(sac_pkg::OP_WRITE, {51'd5, 8'd255, 5'd30}, 0);
    access(sac_pkg::OP_READ, {51'd6, 8'd0, 5'd0}, 0);
    for (int t = 0; t < 9; t++) access(sac_pkg::OP_WRITE, {51'(t + 100), 8'd3, 5'(4*t)}, 0);
    access(sac_pkg::OP_READ, {51'd100, 8'd3, 5'd0}, 0);
    access(sac_pkg::OP_READ, {51'd108, 8'd3, 5'd31}, 0);
    send_beat(sac_pkg::OP_NOP, '1, '1, '1);
    send_beat(sac_pkg::OP_FILL, '0, '0, '1);
    // a miss, then an access offered while its fetch is outstanding
    send_beat(sac_pkg::OP_READ, {51'd200, 8'd9, 5'd0}, '0, '0);
    wait_quiet();
    send_beat(sac_pkg::OP_WRITE, {51'd201, 8'd9, 5'd0}, '1, '0);
    settle(0);

    random_phase(6, 0, 0);
    random_phase(6, 64, 0);
    random_phase(6, 0, 64);
    random_phase(6, 13, 13);

    // hold the response side so the block backs up into its input
    send_idle_pct = 0;
    stall_pct = 0;
    hold_rsp = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rsp = 0;
      end
    join_none
    for (int i = 0; i < 20; i++)
      send_beat(2'($urandom_range(1)), {tag_pool[i % 3], 8'd1, 5'($urandom)}, $urandom, $urandom);
    settle(0);

    wait_quiet();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("set_assoc_writeback_lru_cache_core regression: pass");
    else
      $display("set_assoc_writeback_lru_cache_core regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hdl/sac_pkg.sv
hdl/sac_stream_if.sv
hdl/sac_way_sel.sv
hdl/set_assoc_writeback_lru_cache_core.sv
test/cache_scoreboard.sv
test/tb_top.sv
